// ----- rtl/usmr_pkg.sv -----
package usmr_pkg;

   // Register indexes on the configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 29;
   localparam logic [CSR_IDX_W-1:0] REG_FAIL_CAUSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERIFY_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HB_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REQUEST_ID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RESPONSE_ID = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON_ID = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_HB_PERIOD = 16'd500;
   localparam logic [28:0] RST_REQUEST_ID = 29'h18DA0D03;
   localparam logic [28:0] RST_RESPONSE_ID = 29'h18DA030D;
   localparam logic [28:0] RST_BEACON_ID = 29'h18FF260D;

   // Stream layouts
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 96;
   localparam int unsigned REQ_ID_LSB = 0;
   localparam int unsigned REQ_LEN_LSB = 29;
   localparam int unsigned REQ_BYTE_LSB = 33;
   localparam int unsigned RSP_BYTE_LSB = 29;

   // UDS / ISO-TP codes
   localparam logic [7:0] SID_TESTER_PRESENT = 8'h3E;
   localparam logic [7:0] RSP_TESTER_PRESENT = 8'h7E;
   localparam logic [7:0] SID_READ_DID = 8'h22;
   localparam logic [7:0] RSP_READ_DID = 8'h62;
   localparam logic [7:0] SID_NEG_RSP = 8'h7F;
   localparam logic [7:0] DID_HI = 8'h21;
   localparam logic [7:0] DID_LO = 8'h13;
   localparam logic [7:0] DID_MARK = 8'hFE;
   localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
   localparam logic [7:0] PAD_BYTE = 8'hCC;
   localparam logic [7:0] HB_MAGIC = 8'hA5;

   // Kind of a request item
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // What the back end has to build
   typedef enum logic [1:0] {
      OP_TESTER_PRESENT,
      OP_READ_DID,
      OP_NEG_RSP,
      OP_HEARTBEAT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] sub;
   } entry_type;

endpackage

// ----- rtl/uds_safe_mode_responder.sv -----
// Channel | Dir | Signals                         | Contents
// req     | in  | req_tvalid/tready/tdata/tuser   | received CAN frame or 1 ms tick
// rsp     | out | rsp_tvalid/tready/tdata         | frame to transmit
// csr     | in  | csr_we/csr_index/csr_wdata      | register writes, no read-back
//
// An item is classified in the cycle it is accepted and queued; the back end
// builds the frame from the queue head into the output register once that is empty or drained.
// Sustained rate is one item per cycle while rsp_tready stays high, set by the one-entry-per-cycle queue.
// Synchronous active-high reset clears the queue, output valid and tick state.
// The queue lets requests keep flowing while the output waits on rsp_tready;
// req_tready drops only when all QUEUE_DEPTH entries are in use.
module uds_safe_mode_responder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // frame_id[28:0], frame_len[32:29], rx_byte0..rx_byte7[96:33], zero pad
   input  logic [usmr_pkg::REQ_DATA_W-1:0]       req_tdata,
   // kind
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tx_id[28:0], tx_byte0..tx_byte7[92:29], zero pad
   output logic [usmr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [usmr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [usmr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [7:0]  fail_cause_ff;
   logic [7:0]  verify_step_ff;
   logic [15:0] hb_period_ff;
   logic [28:0] request_id_ff;
   logic [28:0] response_id_ff;
   logic [28:0] beacon_id_ff;

   logic                q_full;
   logic                q_push;
   usmr_pkg::entry_type q_entry;
   logic                q_pop;
   logic                q_head_valid;
   usmr_pkg::entry_type q_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fail_cause_ff <= 8'd0;
         verify_step_ff <= 8'd0;
         hb_period_ff <= usmr_pkg::RST_HB_PERIOD;
         request_id_ff <= usmr_pkg::RST_REQUEST_ID;
         response_id_ff <= usmr_pkg::RST_RESPONSE_ID;
         beacon_id_ff <= usmr_pkg::RST_BEACON_ID;
      end else if (csr_we) begin
         unique case (csr_index)
            usmr_pkg::REG_FAIL_CAUSE:  fail_cause_ff <= csr_wdata[7:0];
            usmr_pkg::REG_VERIFY_STEP: verify_step_ff <= csr_wdata[7:0];
            usmr_pkg::REG_HB_PERIOD:   hb_period_ff <= csr_wdata[15:0];
            usmr_pkg::REG_REQUEST_ID:  request_id_ff <= csr_wdata[28:0];
            usmr_pkg::REG_RESPONSE_ID: response_id_ff <= csr_wdata[28:0];
            usmr_pkg::REG_BEACON_ID:   beacon_id_ff <= csr_wdata[28:0];
            default: begin
            end
         endcase
      end
   end

   usmr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .request_id       (request_id_ff),
      .heartbeat_period (hb_period_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   usmr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   usmr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_entry  (q_head),
      .pop         (q_pop),
      .fail_cause  (fail_cause_ff),
      .verify_step (verify_step_ff),
      .response_id (response_id_ff),
      .beacon_id   (beacon_id_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- rtl/usmr_front.sv -----
module usmr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [usmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic [28:0]                      request_id,
   input  logic [15:0]                      heartbeat_period,
   input  logic                             q_full,
   output logic                             q_push,
   output usmr_pkg::entry_type              q_entry
);

   logic [7:0]  d [8];
   logic [3:0]  len;
   logic [3:0]  pn;
   logic        pci_ok;
   logic [3:0]  un;
   logic [7:0]  u0, u1, u2;
   logic        id_hit;
   logic        is_tp, is_did, is_nrc;
   logic [15:0] period_eff;
   logic [15:0] cnt_inc;
   logic        fire;
   logic        accept;
   logic [15:0] tick_cnt_ff, tick_cnt_in;
   logic        started_ff, started_in;
   usmr_pkg::entry_type entry;
   logic        has_result;

   // unpack the data bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         d[i] = req_tdata[usmr_pkg::REQ_BYTE_LSB + 8*i +: 8];
      end
   end

   // ISO-TP single frame PCI strip
   assign len = (req_tdata[usmr_pkg::REQ_LEN_LSB +: 4] > 4'd8) ? 4'd8 :
                req_tdata[usmr_pkg::REQ_LEN_LSB +: 4];
   assign pn = d[0][3:0];
   assign pci_ok = (len >= 4'd2) && (d[0][7:4] == 4'd0) && (pn != 4'd0) &&
                   (({1'b0, pn} + 5'd1) <= {1'b0, len});
   assign un = pci_ok ? pn : len;
   assign u0 = pci_ok ? d[1] : d[0];
   assign u1 = pci_ok ? d[2] : d[1];
   assign u2 = pci_ok ? d[3] : d[2];

   // service decode
   assign id_hit = (req_tdata[usmr_pkg::REQ_ID_LSB +: 29] == request_id);
   assign is_tp  = (un >= 4'd2) && (u0 == usmr_pkg::SID_TESTER_PRESENT) && !u1[7];
   assign is_did = (un >= 4'd3) && (u0 == usmr_pkg::SID_READ_DID) &&
                   (u1 == usmr_pkg::DID_HI) && (u2 == usmr_pkg::DID_LO);
   assign is_nrc = (un >= 4'd1) && (u0 == usmr_pkg::SID_READ_DID);

   // heartbeat tick counter
   assign period_eff = (heartbeat_period == 16'd0) ? 16'd1 : heartbeat_period;
   assign cnt_inc = (tick_cnt_ff == 16'hFFFF) ? tick_cnt_ff : tick_cnt_ff + 16'd1;

   always_comb begin
      fire = 1'b0;
      tick_cnt_in = tick_cnt_ff;
      started_in = started_ff;
      if (accept && (req_tuser == usmr_pkg::KIND_TICK)) begin
         if (!started_ff) begin
            started_in = 1'b1;
            tick_cnt_in = 16'd0;
            fire = 1'b1;
         end else if (cnt_inc >= period_eff) begin
            tick_cnt_in = 16'd0;
            fire = 1'b1;
         end else begin
            tick_cnt_in = cnt_inc;
         end
      end
   end

   // classify into a queue entry
   always_comb begin
      entry.op = usmr_pkg::OP_HEARTBEAT;
      entry.sub = u1[6:0];
      has_result = 1'b0;
      if (req_tuser == usmr_pkg::KIND_TICK) begin
         has_result = fire;
      end else if (id_hit) begin
         if ((un >= 4'd2) && (u0 == usmr_pkg::SID_TESTER_PRESENT)) begin
            entry.op = usmr_pkg::OP_TESTER_PRESENT;
            has_result = is_tp;
         end else if (is_did) begin
            entry.op = usmr_pkg::OP_READ_DID;
            has_result = 1'b1;
         end else if (is_nrc) begin
            entry.op = usmr_pkg::OP_NEG_RSP;
            has_result = 1'b1;
         end
      end
   end

   assign req_tready = !q_full;
   assign accept = req_tvalid && !q_full;
   assign q_push = accept && has_result;
   assign q_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_cnt_ff <= 16'd0;
         started_ff <= 1'b0;
      end else begin
         tick_cnt_ff <= tick_cnt_in;
         started_ff <= started_in;
      end
   end

endmodule

// ----- rtl/usmr_queue.sv -----
module usmr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  usmr_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output usmr_pkg::entry_type head_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   usmr_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

// ----- rtl/usmr_back.sv -----
module usmr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  usmr_pkg::entry_type              head_entry,
   output logic                             pop,
   input  logic [7:0]                       fail_cause,
   input  logic [7:0]                       verify_step,
   input  logic [28:0]                      response_id,
   input  logic [28:0]                      beacon_id,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [usmr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [28:0] tx_id;
   logic [7:0]  b [8];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [usmr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // frame build from the queued entry
   always_comb begin
      tx_id = response_id;
      for (int i = 0; i < 8; i++) begin
         b[i] = usmr_pkg::PAD_BYTE;
      end
      unique case (head_entry.op)
         usmr_pkg::OP_TESTER_PRESENT: begin
            b[0] = 8'd2;
            b[1] = usmr_pkg::RSP_TESTER_PRESENT;
            b[2] = {1'b0, head_entry.sub};
         end
         usmr_pkg::OP_READ_DID: begin
            b[0] = 8'd5;
            b[1] = usmr_pkg::RSP_READ_DID;
            b[2] = usmr_pkg::DID_HI;
            b[3] = usmr_pkg::DID_LO;
            b[4] = usmr_pkg::DID_MARK;
            b[5] = verify_step;
         end
         usmr_pkg::OP_NEG_RSP: begin
            b[0] = 8'd3;
            b[1] = usmr_pkg::SID_NEG_RSP;
            b[2] = usmr_pkg::SID_READ_DID;
            b[3] = usmr_pkg::NRC_NOT_SUPPORTED;
         end
         usmr_pkg::OP_HEARTBEAT: begin
            tx_id = beacon_id;
            b[0] = 8'h01;
            b[1] = 8'h41;
            b[2] = 8'h42;
            b[3] = 8'h54;
            b[4] = fail_cause;
            b[5] = verify_step;
            b[6] = usmr_pkg::HB_MAGIC;
            b[7] = 8'h00;
         end
         default: begin
            tx_id = response_id;
         end
      endcase
   end

   // output register: load when empty or being drained
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {3'b000, b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0], tx_id};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
